FILE: hdl/cfb_pkg.sv
// Shared types, constants and the CRC8 fold for the CRSF frame builder.
`default_nettype none

package cfb_pkg;

    // Command codes on the input channel.
    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_PAYLOAD = 1'b1;

    // Frame constants.
    localparam logic [7:0] SYNC_BYTE = 8'hC8;
    localparam logic [7:0] CRC_POLY  = 8'hD5;

    // Defaults for the top-level parameters.
    localparam int MAX_PAYLOAD_DEF = 60;
    localparam int QUEUE_DEPTH_DEF = 4;

    // One queue entry: up to four frame bytes, sent from slot 0 up to last_idx.
    typedef struct packed {
        logic [1:0]      last_idx;
        logic            crc_end;
        logic [3:0][7:0] bytes;
    } entry_t;

    // Front to queue.
    typedef struct packed {
        logic   valid;
        entry_t entry;
    } push_t;

    // Queue to back.
    typedef struct packed {
        logic   empty;
        entry_t entry;
    } head_t;

    // CRC8, MSB first, no reflection, no final xor.
    function automatic logic [7:0] crc8_fold(logic [7:0] crc, logic [7:0] data);
        logic [7:0] v;
        v = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (v[7]) begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/cfb_front.sv
// Front end: accepts commands, tracks the open frame and the CRC, builds queue entries.
`default_nettype none

module cfb_front
    import cfb_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_command,
    input  wire logic [7:0] s_frame_type,
    input  wire logic [5:0] s_payload_length,
    input  wire logic [7:0] s_data_byte,
    input  wire logic       q_full,
    output push_t           q_push
);

    logic [7:0] crc_reg, crc_next;
    logic [5:0] rem_reg, rem_next;
    logic       open_reg, open_next;

    logic       accept;
    logic [7:0] type_crc;
    logic [7:0] data_crc;
    logic [5:0] rem_dec;
    logic       too_long;

    assign s_ready  = !q_full;
    assign accept   = s_valid && s_ready;
    assign type_crc = crc8_fold(8'h00, s_frame_type);
    assign data_crc = crc8_fold(crc_reg, s_data_byte);
    assign rem_dec  = (rem_reg != 6'd0) ? (rem_reg - 6'd1) : rem_reg;
    assign too_long = ({2'b00, s_payload_length} > 8'(MAX_PAYLOAD));

    always_comb begin
        crc_next     = crc_reg;
        rem_next     = rem_reg;
        open_next    = open_reg;
        q_push       = '0;
        if (accept) begin
            unique case (s_command)
                CMD_START: begin
                    open_next = 1'b0;
                    rem_next  = 6'd0;
                    if (!too_long) begin
                        crc_next                = type_crc;
                        q_push.valid            = 1'b1;
                        q_push.entry.bytes[0]   = SYNC_BYTE;
                        q_push.entry.bytes[1]   = {2'b00, s_payload_length} + 8'd2;
                        q_push.entry.bytes[2]   = s_frame_type;
                        q_push.entry.bytes[3]   = type_crc;
                        if (s_payload_length == 6'd0) begin
                            q_push.entry.last_idx = 2'd3;
                            q_push.entry.crc_end  = 1'b1;
                        end else begin
                            q_push.entry.last_idx = 2'd2;
                            rem_next              = s_payload_length;
                            open_next             = 1'b1;
                        end
                    end
                end
                CMD_PAYLOAD: begin
                    if (open_reg) begin
                        crc_next              = data_crc;
                        rem_next              = rem_dec;
                        q_push.valid          = 1'b1;
                        q_push.entry.bytes[0] = s_data_byte;
                        q_push.entry.bytes[1] = data_crc;
                        if (rem_dec == 6'd0) begin
                            // Last payload byte: the CRC byte closes the frame.
                            q_push.entry.last_idx = 2'd1;
                            q_push.entry.crc_end  = 1'b1;
                            open_next             = 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg  <= 8'h00;
            rem_reg  <= 6'd0;
            open_reg <= 1'b0;
        end else begin
            crc_reg  <= crc_next;
            rem_reg  <= rem_next;
            open_reg <= open_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/cfb_queue.sv
// Short register queue of frame entries between the front and back ends.
`default_nettype none

module cfb_queue
    import cfb_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire push_t q_push,
    input  wire logic  q_pop,
    output logic       q_full,
    output head_t      q_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    entry_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              do_push;
    logic              do_pop;

    assign q_full       = (cnt_reg == CNT_W'(DEPTH));
    assign q_head.empty = (cnt_reg == '0);
    assign q_head.entry = mem_reg[rd_ptr_reg];
    assign do_push      = q_push.valid && !q_full;
    assign do_pop       = q_pop && !q_head.empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= q_push.entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/cfb_back.sv
// Back end: one head entry byte per cycle to output register unless stalled.
`default_nettype none

module cfb_back
    import cfb_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire head_t q_head,
    output logic       q_pop,
    output logic       m_valid,
    input  wire logic  m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_frame_end
);

    logic       m_valid_reg, m_valid_next;
    logic [7:0] byte_reg;
    logic       end_reg;
    logic [1:0] idx_reg, idx_next;
    logic       load;
    logic       at_last;

    assign load    = !q_head.empty && (!m_valid_reg || m_ready);
    assign at_last = (idx_reg == q_head.entry.last_idx);
    assign q_pop   = load && at_last;

    always_comb begin
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (load) begin
            m_valid_next = 1'b1;
            idx_next     = at_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= q_head.entry.bytes[idx_reg];
            end_reg  <= q_head.entry.crc_end && at_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            idx_reg     <= 2'd0;
        end else begin
            m_valid_reg <= m_valid_next;
            idx_reg     <= idx_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_byte  = byte_reg;
    assign m_frame_end = end_reg;

endmodule

`default_nettype wire

FILE: hdl/crsf_frame_builder_crc8_top.sv
// Top level of the CRSF frame builder with DVB-S2 CRC8.
//
//  Channel  Direction  Handshake           Payload
//  s_       in         s_valid / s_ready   s_command, s_frame_type, s_payload_length, s_data_byte
//  m_       out        m_valid / m_ready   m_out_byte, m_frame_end
//
// An input transfer can be taken every cycle while the entry queue has room; the
// front end folds a byte into the CRC in the same cycle it accepts it.
// The output side delivers one frame byte per cycle while m_ready holds, so a start gives three
// or four output bytes and a payload byte one or two; the output port sets the sustained rate.
// Reset is synchronous and active low; it closes any open frame and empties the queue.
// Either side may stall on its own: the queue absorbs up to QUEUE_DEPTH entries.
`default_nettype none

module crsf_frame_builder_crc8_top
    import cfb_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_command,
    input  wire logic [7:0] s_frame_type,
    input  wire logic [5:0] s_payload_length,
    input  wire logic [7:0] s_data_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_frame_end
);

    // Entries carry up to four bytes from the front end to the back end.
    push_t q_push;
    head_t q_head;
    logic  q_full;
    logic  q_pop;

    // The front end classifies each transfer and keeps the frame state.
    cfb_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_frame_type     (s_frame_type),
        .s_payload_length (s_payload_length),
        .s_data_byte      (s_data_byte),
        .q_full           (q_full),
        .q_push           (q_push)
    );

    // The queue decouples the two sides.
    cfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_push  (q_push),
        .q_pop   (q_pop),
        .q_full  (q_full),
        .q_head  (q_head)
    );

    // The back end serializes entries onto the output channel.
    cfb_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_frame_end (m_frame_end)
    );

`ifndef SYNTHESIS
    // An entry enters the queue only for an accepted input transfer.
    a_push_needs_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push.valid |-> (s_valid && s_ready))
        else $error("queue push without an input transfer");

    // The back end never retires an entry from an empty queue.
    a_pop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_head.empty)
        else $error("queue pop while empty");

    // A start over the length bound produces no entry.
    a_long_start_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_command == CMD_START)
            && ({2'b00, s_payload_length} > 8'(MAX_PAYLOAD))) |-> !q_push.valid)
        else $error("oversized start produced output");

    // A valid start always opens its entry with the sync byte.
    a_start_sync: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_command == CMD_START)
            && ({2'b00, s_payload_length} <= 8'(MAX_PAYLOAD)))
            |-> (q_push.valid && (q_push.entry.bytes[0] == SYNC_BYTE)))
        else $error("start entry missing sync byte");
`endif

endmodule

`default_nettype wire
